[hw/rtl/cursor_sprite_alpha_blend_top_macros.svh]
// Assertion macros for the cursor sprite blend checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef CURSOR_SPRITE_ALPHA_BLEND_TOP_MACROS_SVH
`define CURSOR_SPRITE_ALPHA_BLEND_TOP_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define CSPR_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The expression must never be true at a clock edge outside reset.
`define CSPR_ASSERT_NEVER(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

[hw/rtl/cspr_pkg.sv]
package cspr_pkg;

    localparam logic FMT_RGB565   = 1'b0;
    localparam logic FMT_ARGB8888 = 1'b1;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 12;

    localparam logic [CFG_IDX_BITS-1:0] REG_PIXEL_FORMAT  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_HOT_X         = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_HOT_Y         = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPRITE_WIDTH  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPRITE_HEIGHT = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_CURSOR_ENABLE = 3'd7;

    localparam logic [11:0] SCREEN_WIDTH_RESET  = 12'd640;
    localparam logic [11:0] SCREEN_HEIGHT_RESET = 12'd480;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    localparam int NUM_CHAN = 3;

    typedef struct packed {
        logic        pixel_format;
        logic [11:0] screen_width;
        logic [11:0] screen_height;
        logic [5:0]  hot_x;
        logic [5:0]  hot_y;
        logic [6:0]  sprite_width;
        logic [6:0]  sprite_height;
        logic        cursor_enable;
    } cfg_t;

    typedef struct packed {
        logic        hit;
        logic [11:0] x;
        logic [11:0] y;
    } place_t;

    // Exact truncating divide by 255 for sums up to 255 * 255.
    function automatic logic [7:0] div255(input logic [16:0] sum);
        logic [16:0] q;
        q = (sum + (sum >> 8) + 17'd1) >> 8;
        return q[7:0];
    endfunction

endpackage

[hw/rtl/cspr_place.sv]
module cspr_place #(
    parameter int SPRITE_MAX = 64,
    parameter int COORD_BITS = 13
) (
    input  cspr_pkg::cfg_t                cfg,
    input  logic signed [COORD_BITS-1:0]  cursor_x,
    input  logic signed [COORD_BITS-1:0]  cursor_y,
    input  logic [5:0]                    sprite_col,
    input  logic [5:0]                    sprite_row,
    input  logic [7:0]                    src_alpha,
    output cspr_pkg::place_t              place
);

    localparam int XW = ((COORD_BITS > 12) ? COORD_BITS : 12) + 2;

    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic                 in_sprite;
    logic                 x_ok;
    logic                 y_ok;

    always_comb
    begin
        dx = XW'(cursor_x) - $signed(XW'(cfg.hot_x)) + $signed(XW'(sprite_col));
        dy = XW'(cursor_y) - $signed(XW'(cfg.hot_y)) + $signed(XW'(sprite_row));

        in_sprite = cfg.cursor_enable
                    && ({1'b0, sprite_col} < cfg.sprite_width)
                    && ({1'b0, sprite_row} < cfg.sprite_height)
                    && (int'(sprite_col) < SPRITE_MAX)
                    && (int'(sprite_row) < SPRITE_MAX);

        x_ok = !dx[XW-1] && (dx < $signed(XW'(cfg.screen_width)));
        y_ok = !dy[XW-1] && (dy < $signed(XW'(cfg.screen_height)));

        place.hit = in_sprite && x_ok && y_ok && (src_alpha != 8'd0);
        place.x   = dx[11:0];
        place.y   = dy[11:0];
    end

endmodule

[hw/rtl/cspr_blend.sv]
module cspr_blend (
    input  logic        pixel_format,
    input  logic [7:0]  src_red,
    input  logic [7:0]  src_green,
    input  logic [7:0]  src_blue,
    input  logic [7:0]  src_alpha,
    input  logic [31:0] dest_pixel,
    output logic [31:0] pixel
);

    logic [cspr_pkg::NUM_CHAN-1:0][7:0]  src_chan;
    logic [cspr_pkg::NUM_CHAN-1:0][7:0]  dst_chan;
    logic [7:0]                          inv_alpha;
    logic [cspr_pkg::NUM_CHAN-1:0][15:0] src_prod;
    logic [cspr_pkg::NUM_CHAN-1:0][15:0] dst_prod;
    logic [cspr_pkg::NUM_CHAN-1:0][7:0]  mix_chan;

    always_comb
    begin
        src_chan[0] = src_red;
        src_chan[1] = src_green;
        src_chan[2] = src_blue;
        if (pixel_format == cspr_pkg::FMT_RGB565)
        begin
            dst_chan[0] = {dest_pixel[15:11], 3'b000};
            dst_chan[1] = {dest_pixel[10:5], 2'b00};
            dst_chan[2] = {dest_pixel[4:0], 3'b000};
        end
        else
        begin
            dst_chan[0] = dest_pixel[23:16];
            dst_chan[1] = dest_pixel[15:8];
            dst_chan[2] = dest_pixel[7:0];
        end
        inv_alpha = cspr_pkg::ALPHA_OPAQUE - src_alpha;
        for (int i = 0; i < cspr_pkg::NUM_CHAN; i++)
        begin
            src_prod[i] = 16'(src_chan[i]) * 16'(src_alpha);
            dst_prod[i] = 16'(dst_chan[i]) * 16'(inv_alpha);
            mix_chan[i] = cspr_pkg::div255(17'(src_prod[i]) + 17'(dst_prod[i]));
        end
        if (pixel_format == cspr_pkg::FMT_RGB565)
        begin
            pixel = {16'h0000, mix_chan[0][7:3], mix_chan[1][7:2], mix_chan[2][7:3]};
        end
        else
        begin
            pixel = {cspr_pkg::ALPHA_OPAQUE, mix_chan[0], mix_chan[1], mix_chan[2]};
        end
    end

endmodule

[hw/rtl/cursor_sprite_alpha_blend_top.sv]
// Hardware cursor overlay that takes one sprite pixel per clock and returns one
// transaction for each pixel accepted, through the input register and then the
// result register, marked by done for exactly one cycle. Placement, clipping and
// the channel blend are done in one combinational pass between those two
// registers; start is never refused, so busy stays low.
// The receiver cannot stall, so done must be captured in the cycle it is high.
// When write_enable is low the coordinates and new_pixel read as zero.
// Configuration registers are written through cfg_we, cfg_addr and cfg_wdata
// and must only change while no transaction is in flight.
module cursor_sprite_alpha_blend_top #(
    parameter int SPRITE_MAX = 64,
    parameter int COORD_BITS = 13
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [cspr_pkg::CFG_IDX_BITS-1:0]     cfg_addr,
    input  logic [cspr_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [COORD_BITS-1:0]          cursor_x,
    input  logic signed [COORD_BITS-1:0]          cursor_y,
    input  logic [5:0]                            sprite_col,
    input  logic [5:0]                            sprite_row,
    input  logic [7:0]                            src_red,
    input  logic [7:0]                            src_green,
    input  logic [7:0]                            src_blue,
    input  logic [7:0]                            src_alpha,
    input  logic [31:0]                           dest_pixel,
    output logic                                  done,
    output logic                                  write_enable,
    output logic [11:0]                           screen_x,
    output logic [11:0]                           screen_y,
    output logic [31:0]                           new_pixel
);

    cspr_pkg::cfg_t               cfg_reg;
    cspr_pkg::cfg_t               cfg_next;

    logic                         in_vld_reg;
    logic                         in_vld_next;
    logic signed [COORD_BITS-1:0] cursor_x_reg;
    logic signed [COORD_BITS-1:0] cursor_y_reg;
    logic [5:0]                   sprite_col_reg;
    logic [5:0]                   sprite_row_reg;
    logic [7:0]                   src_red_reg;
    logic [7:0]                   src_green_reg;
    logic [7:0]                   src_blue_reg;
    logic [7:0]                   src_alpha_reg;
    logic [31:0]                  dest_pixel_reg;

    cspr_pkg::place_t             place;
    logic [31:0]                  blend_pixel;

    logic                         done_reg;
    logic                         write_enable_reg;
    logic [11:0]                  screen_x_reg;
    logic [11:0]                  screen_y_reg;
    logic [31:0]                  new_pixel_reg;

    assign busy        = 1'b0;
    assign in_vld_next = start && !busy;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                cspr_pkg::REG_PIXEL_FORMAT:  cfg_next.pixel_format  = cfg_wdata[0];
                cspr_pkg::REG_SCREEN_WIDTH:  cfg_next.screen_width  = cfg_wdata[11:0];
                cspr_pkg::REG_SCREEN_HEIGHT: cfg_next.screen_height = cfg_wdata[11:0];
                cspr_pkg::REG_HOT_X:         cfg_next.hot_x         = cfg_wdata[5:0];
                cspr_pkg::REG_HOT_Y:         cfg_next.hot_y         = cfg_wdata[5:0];
                cspr_pkg::REG_SPRITE_WIDTH:  cfg_next.sprite_width  = cfg_wdata[6:0];
                cspr_pkg::REG_SPRITE_HEIGHT: cfg_next.sprite_height = cfg_wdata[6:0];
                cspr_pkg::REG_CURSOR_ENABLE: cfg_next.cursor_enable = cfg_wdata[0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pixel_format  <= cspr_pkg::FMT_RGB565;
            cfg_reg.screen_width  <= cspr_pkg::SCREEN_WIDTH_RESET;
            cfg_reg.screen_height <= cspr_pkg::SCREEN_HEIGHT_RESET;
            cfg_reg.hot_x         <= 6'd0;
            cfg_reg.hot_y         <= 6'd0;
            cfg_reg.sprite_width  <= 7'd0;
            cfg_reg.sprite_height <= 7'd0;
            cfg_reg.cursor_enable <= 1'b0;
            in_vld_reg            <= 1'b0;
            done_reg              <= 1'b0;
        end
        else
        begin
            cfg_reg    <= cfg_next;
            in_vld_reg <= in_vld_next;
            done_reg   <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_vld_next)
        begin
            cursor_x_reg   <= cursor_x;
            cursor_y_reg   <= cursor_y;
            sprite_col_reg <= sprite_col;
            sprite_row_reg <= sprite_row;
            src_red_reg    <= src_red;
            src_green_reg  <= src_green;
            src_blue_reg   <= src_blue;
            src_alpha_reg  <= src_alpha;
            dest_pixel_reg <= dest_pixel;
        end
        write_enable_reg <= place.hit;
        screen_x_reg     <= place.hit ? place.x : 12'd0;
        screen_y_reg     <= place.hit ? place.y : 12'd0;
        new_pixel_reg    <= place.hit ? blend_pixel : 32'd0;
    end

    cspr_place #(
        .SPRITE_MAX (SPRITE_MAX),
        .COORD_BITS (COORD_BITS)
    ) u_place (
        .cfg        (cfg_reg),
        .cursor_x   (cursor_x_reg),
        .cursor_y   (cursor_y_reg),
        .sprite_col (sprite_col_reg),
        .sprite_row (sprite_row_reg),
        .src_alpha  (src_alpha_reg),
        .place      (place)
    );

    cspr_blend u_blend (
        .pixel_format (cfg_reg.pixel_format),
        .src_red      (src_red_reg),
        .src_green    (src_green_reg),
        .src_blue     (src_blue_reg),
        .src_alpha    (src_alpha_reg),
        .dest_pixel   (dest_pixel_reg),
        .pixel        (blend_pixel)
    );

    assign done         = done_reg;
    assign write_enable = write_enable_reg;
    assign screen_x     = screen_x_reg;
    assign screen_y     = screen_y_reg;
    assign new_pixel    = new_pixel_reg;

endmodule

[hw/rtl/cspr_chk.sv]
`include "cursor_sprite_alpha_blend_top_macros.svh"

module cspr_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [7:0]  src_alpha,
    input logic        done,
    input logic        write_enable,
    input logic [11:0] screen_x,
    input logic [11:0] screen_y,
    input logic [31:0] new_pixel
);

    logic accepted;
    logic alpha_zero;
    logic wrote;
    logic skipped;
    logic fields_clear;
    logic pixel_shape_ok;

    assign accepted       = start && !busy && rst_n;
    assign alpha_zero     = (src_alpha == 8'd0);
    assign wrote          = done && write_enable;
    assign skipped        = done && !write_enable;
    assign fields_clear   = (screen_x == 12'd0) && (screen_y == 12'd0) && (new_pixel == 32'd0);
    assign pixel_shape_ok = (new_pixel[31:24] == 8'hFF) || (new_pixel[31:16] == 16'h0000);

    // Every accepted transaction returns exactly one result, and done never rises without one.
    `CSPR_ASSERT(a_latency, done == $past(accepted, 2), "result strobe out of step with input")

    // A transparent source pixel is never written.
    `CSPR_ASSERT_NEVER(a_transparent, wrote && $past(alpha_zero, 2), "transparent pixel written")

    // A result without a write carries all-zero fields.
    `CSPR_ASSERT_NEVER(a_no_write_zero, skipped && !fields_clear, "skipped result not zero")

    // A written pixel is either RGB565 with a clear upper half or opaque ARGB8888.
    `CSPR_ASSERT_NEVER(a_pixel_shape, wrote && !pixel_shape_ok, "malformed upper half")

endmodule

bind cursor_sprite_alpha_blend_top cspr_chk u_cspr_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .src_alpha    (src_alpha),
    .done         (done),
    .write_enable (write_enable),
    .screen_x     (screen_x),
    .screen_y     (screen_y),
    .new_pixel    (new_pixel)
);
